// ===== design/sotc_pkg.sv =====
// ----------------------------------------------------------------------------
// Striping address map package
// Register indexes, reset values and pipeline timing shared by the top level
// and its checker.
// ----------------------------------------------------------------------------
package sotc_pkg;

   typedef enum logic [2:0] {
      CSR_STRIPE_UNIT = 3'd0,
      CSR_DATA_WIDTH  = 3'd1,
      CSR_ROWS        = 3'd2,
      CSR_GROUPS      = 3'd3,
      CSR_COPIES      = 3'd4
   } csr_index_type;

   localparam logic [31:0] SU_RESET   = 32'd65536;
   localparam logic [15:0] DW_RESET   = 16'd1;
   localparam logic [63:0] ROWS_RESET = '1;
   localparam logic [15:0] GT_RESET   = 16'd1;
   localparam logic [8:0]  CP_RESET   = 9'd1;

   // Busy countdown loaded on reset and on every register write while the derived span registers follow the new values
   localparam int unsigned SETTLE_CYCLES = 5;

   // Divider chain 64 + 64 + 64 + 32 stages, one group offset fold stage,
   // then three arithmetic stages
   localparam int unsigned PIPE_LATENCY = 228;

endpackage

// ===== design/stripe_offset_to_component_map_top.sv =====
// ----------------------------------------------------------------------------
// Striping address map
// Maps a file byte offset through a grouped, mirrored striped layout.
//
//   channel   ports                      handshake
//   request   start, busy, req_*         taken when start && !busy
//   response  rsp_valid, rsp_*           one-cycle strobe, no back-pressure
//   config    csr_valid, csr_ready, csr_* written when valid && ready
//
// One request per cycle while busy is low; each response passes through the
// chain of bit-per-stage dividers (64 + 64 + 64 + 32 stages), one
// stage that folds the high group quotient bits into the in-group offset,
// plus three multiply/add stages.
// busy is high after reset and after any register write while the derived
// spans (row, group, full span) recompute.
// Reset drops all requests in flight. The response side never stalls.
// ----------------------------------------------------------------------------
module stripe_offset_to_component_map_top import sotc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_file_offset,
   output logic        rsp_valid,
   output logic [31:0] rsp_component_index,
   output logic [63:0] rsp_object_offset,
   output logic [31:0] rsp_unit_offset,
   output logic [63:0] rsp_group_remaining,
   output logic [63:0] rsp_group_span,
   output logic [63:0] rsp_major_row,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic [31:0] su_ff;
   logic [15:0] dw_ff;
   logic [63:0] rows_ff;
   logic [15:0] gt_ff;
   logic [8:0]  cp_ff;
   logic [2:0]  settle_ff;
   logic        csr_write;
   logic        accept;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign busy      = settle_ff != 3'd0;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         su_ff     <= SU_RESET;
         dw_ff     <= DW_RESET;
         rows_ff   <= ROWS_RESET;
         gt_ff     <= GT_RESET;
         cp_ff     <= CP_RESET;
         settle_ff <= 3'(SETTLE_CYCLES);
      end else if (csr_write) begin
         settle_ff <= 3'(SETTLE_CYCLES);
         unique case (csr_index_type'(csr_index))
            CSR_STRIPE_UNIT: su_ff   <= csr_wdata[31:0];
            CSR_DATA_WIDTH:  dw_ff   <= csr_wdata[15:0];
            CSR_ROWS:        rows_ff <= csr_wdata;
            CSR_GROUPS:      gt_ff   <= csr_wdata[15:0];
            CSR_COPIES:      cp_ff   <= csr_wdata[8:0];
            default: ;
         endcase
      end else if (settle_ff != 3'd0) begin
         settle_ff <= settle_ff - 3'd1;
      end
   end

   // Derived spans, all modulo their width
   logic [31:0] u_ff;
   logic [63:0] tlo_ff, rlo_ff, t_ff, r_ff, s_ff;
   logic [31:0] thi_ff, rhi_ff, shi_ff;
   logic [47:0] slo_ff;
   logic [47:0] u_full;

   assign u_full = 48'(su_ff) * 48'(dw_ff);

   always_ff @(posedge clock) begin
      u_ff   <= u_full[31:0];
      rlo_ff <= 64'(rows_ff[31:0]) * 64'(su_ff);
      rhi_ff <= 32'(rows_ff[63:32] * su_ff);
      tlo_ff <= 64'(u_ff) * 64'(rows_ff[31:0]);
      thi_ff <= 32'(u_ff * rows_ff[63:32]);
      r_ff   <= rlo_ff + {rhi_ff, 32'd0};
      t_ff   <= tlo_ff + {thi_ff, 32'd0};
      slo_ff <= 48'(t_ff[31:0]) * 48'(gt_ff);
      shi_ff <= 32'(t_ff[63:32] * 32'(gt_ff));
      s_ff   <= 64'(slo_ff) + {shi_ff, 32'd0};
   end

   // Major row and offset within the full span, and offset within the stripe unit
   logic        d1_valid;
   logic [63:0] d1_quo, d1_rem;
   logic        d1_side;
   logic [31:0] d4_rem;
   logic [63:0] d4_quo;
   logic        d4_valid;
   logic        d4_side;

   sotc_div #(.NUM_W(64), .DEN_W(64), .SIDE_W(1)) u_div_major (
      .clock, .reset,
      .in_valid (accept),
      .in_num   (req_file_offset),
      .den      (s_ff),
      .in_side  (1'b0),
      .out_valid(d1_valid),
      .out_quo  (d1_quo),
      .out_rem  (d1_rem),
      .out_side (d1_side)
   );

   sotc_div #(.NUM_W(64), .DEN_W(32), .SIDE_W(1)) u_div_unit (
      .clock, .reset,
      .in_valid (accept),
      .in_num   (req_file_offset),
      .den      (su_ff),
      .in_side  (1'b0),
      .out_valid(d4_valid),
      .out_quo  (d4_quo),
      .out_rem  (d4_rem),
      .out_side (d4_side)
   );

   // Group index and offset within the group
   logic         d2_valid;
   logic [63:0]  d2_quo, d2_rem;
   logic [95:0]  d2_side;

   sotc_div #(.NUM_W(64), .DEN_W(64), .SIDE_W(96)) u_div_group (
      .clock, .reset,
      .in_valid (d1_valid),
      .in_num   (d1_rem),
      .den      (t_ff),
      .in_side  ({d1_quo, d4_rem}),
      .out_valid(d2_valid),
      .out_quo  (d2_quo),
      .out_rem  (d2_rem),
      .out_side (d2_side)
   );

   // The group index keeps only 32 bits, so add back the dropped quotient
   // bits times the group span into the in-group offset
   logic         h_valid_ff;
   logic [63:0]  h_ff;
   logic [31:0]  h_g_ff;
   logic [95:0]  h_side_ff;
   logic [31:0]  h_fix;

   assign h_fix = 32'(d2_quo[63:32] * t_ff[31:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else begin
         h_valid_ff <= d2_valid;
      end
      h_ff      <= d2_rem + {h_fix, 32'd0};
      h_g_ff    <= d2_quo[31:0];
      h_side_ff <= d2_side;
   end

   // Row within the group and offset within the row
   logic         d3_valid;
   logic [63:0]  d3_quo;
   logic [31:0]  d3_rem;
   logic [191:0] d3_side;

   sotc_div #(.NUM_W(64), .DEN_W(32), .SIDE_W(192)) u_div_row (
      .clock, .reset,
      .in_valid (h_valid_ff),
      .in_num   (h_ff),
      .den      (u_ff),
      .in_side  ({h_side_ff, h_g_ff, h_ff}),
      .out_valid(d3_valid),
      .out_quo  (d3_quo),
      .out_rem  (d3_rem),
      .out_side (d3_side)
   );

   // Stripe unit within the row
   logic         d5_valid;
   logic [31:0]  d5_quo;
   logic [31:0]  d5_rem;
   logic [223:0] d5_side;

   sotc_div #(.NUM_W(32), .DEN_W(32), .SIDE_W(224)) u_div_col (
      .clock, .reset,
      .in_valid (d3_valid),
      .in_num   (d3_rem),
      .den      (su_ff),
      .in_side  ({d3_side, d3_quo[31:0]}),
      .out_valid(d5_valid),
      .out_quo  (d5_quo),
      .out_rem  (d5_rem),
      .out_side (d5_side)
   );

   logic [63:0] e_m, e_h;
   logic [31:0] e_uoff, e_g, e_n;

   assign {e_m, e_uoff, e_g, e_h, e_n} = d5_side;

   // Stage A: products
   logic        a_valid_ff;
   logic [31:0] a_nsu_ff, a_gdw_ff, a_mlh_ff, a_mhl_ff, a_col_ff, a_uoff_ff;
   logic [63:0] a_mll_ff, a_m_ff, a_h_ff;

   // Stage B: sums
   logic        b_valid_ff;
   logic [31:0] b_dev_ff, b_uoff_ff;
   logic [63:0] b_obj_ff, b_grem_ff, b_m_ff;
   logic [31:0] b_low;

   assign b_low = a_uoff_ff + a_nsu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         rsp_valid  <= 1'b0;
      end else begin
         a_valid_ff <= d5_valid;
         b_valid_ff <= a_valid_ff;
         rsp_valid  <= b_valid_ff;
      end
      a_nsu_ff  <= 32'(e_n * su_ff);
      a_gdw_ff  <= 32'(e_g * 32'(dw_ff));
      a_mll_ff  <= 64'(e_m[31:0]) * 64'(r_ff[31:0]);
      a_mlh_ff  <= 32'(e_m[31:0] * r_ff[63:32]);
      a_mhl_ff  <= 32'(e_m[63:32] * r_ff[31:0]);
      a_col_ff  <= d5_quo;
      a_uoff_ff <= e_uoff;
      a_m_ff    <= e_m;
      a_h_ff    <= e_h;

      b_dev_ff  <= a_col_ff + a_gdw_ff;
      b_obj_ff  <= 64'(b_low) + a_mll_ff + {a_mlh_ff + a_mhl_ff, 32'd0};
      b_grem_ff <= t_ff - a_h_ff;
      b_uoff_ff <= a_uoff_ff;
      b_m_ff    <= a_m_ff;

      rsp_component_index <= 32'(b_dev_ff * 32'(cp_ff));
      rsp_object_offset   <= b_obj_ff;
      rsp_unit_offset     <= b_uoff_ff;
      rsp_group_remaining <= b_grem_ff;
      rsp_group_span      <= t_ff;
      rsp_major_row       <= b_m_ff;
   end

endmodule

// ===== design/sotc_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, NUM_W stages. The caller must hold the divisor
// stable; the divider does not enforce it. A zero divisor gives an all-ones
// quotient and the dividend's low bits as remainder.
// ----------------------------------------------------------------------------
module sotc_div #(
   parameter int NUM_W  = 64,
   parameter int DEN_W  = 64,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quo,
   output logic [DEN_W-1:0]  out_rem,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [NUM_W];
   logic [NUM_W-1:0]  acc_ff   [NUM_W];
   logic [DEN_W-1:0]  rem_ff   [NUM_W];
   logic [SIDE_W-1:0] side_ff  [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic              src_valid;
      logic [NUM_W-1:0]  src_acc;
      logic [DEN_W-1:0]  src_rem;
      logic [SIDE_W-1:0] src_side;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              fits;
      logic [NUM_W-1:0]  acc_in;
      logic [DEN_W-1:0]  rem_in;

      if (i == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_acc   = in_num;
         assign src_rem   = '0;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[i-1];
         assign src_acc   = acc_ff[i-1];
         assign src_rem   = rem_ff[i-1];
         assign src_side  = side_ff[i-1];
      end

      always_comb begin
         trial  = {src_rem, src_acc[NUM_W-1]};
         diff   = trial - {1'b0, den};
         fits   = trial >= {1'b0, den};
         acc_in = {src_acc[NUM_W-2:0], fits};
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= src_valid;
         end
         acc_ff[i]  <= acc_in;
         rem_ff[i]  <= rem_in;
         side_ff[i] <= src_side;
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = acc_ff[NUM_W-1];
   assign out_rem   = rem_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

// ===== design/sotc_chk.sv =====
// ----------------------------------------------------------------------------
// Striping address map checker
// Port-level timing checks for request, response and register writes.
// ----------------------------------------------------------------------------
module sotc_chk import sotc_pkg::*; (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic csr_valid,
   input logic csr_ready
);

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && busy)
      else $error("response or ready seen right after reset");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> busy)
      else $error("request taken while spans recompute");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##PIPE_LATENCY rsp_valid)
      else $error("request lost");

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LATENCY))
      else $error("response without request");

endmodule

bind stripe_offset_to_component_map_top sotc_chk u_sotc_chk (.*);

// ===== bench/tb_stripe_offset_to_component_map_top.sv =====
// ----------------------------------------------------------------------------
// Striping address map testbench
// Drives file offsets through a series of layout settings, predicts every
// response from the layout registers, and compares field by field.
// ----------------------------------------------------------------------------
module tb_stripe_offset_to_component_map_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sotc_pkg::*;

   typedef enum logic [1:0] {OP_MAP, OP_CSR, OP_DRAIN} op_kind_type;

   typedef struct {
      op_kind_type kind;
      logic [2:0]  idx;
      logic [63:0] data;
   } op_type;

   typedef struct {
      logic [31:0] component_index;
      logic [63:0] object_offset;
      logic [31:0] unit_offset;
      logic [63:0] group_remaining;
      logic [63:0] group_span;
      logic [63:0] major_row;
   } mapping_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [63:0] req_file_offset;
   logic        rsp_valid;
   logic [31:0] rsp_component_index;
   logic [63:0] rsp_object_offset;
   logic [31:0] rsp_unit_offset;
   logic [63:0] rsp_group_remaining;
   logic [63:0] rsp_group_span;
   logic [63:0] rsp_major_row;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   stripe_offset_to_component_map_top DUT (.*);

   // layout copy, zero-extended like the hardware registers
   logic [31:0] lay_su;
   logic [31:0] lay_dw;
   logic [63:0] lay_rows;
   logic [31:0] lay_gt;
   logic [31:0] lay_cp;

   op_type      pending_ops[$];
   mapping_type expected_maps[$];
   int          errors;
   int          n_maps;
   int          n_csr;
   int          hold;
   bit          burst;
   bit          done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic mapping_type map_offset(logic [63:0] off);
      mapping_type r;
      logic [31:0] u, g, n, uoff, low, inrow, dev;
      logic [63:0] t, s, m, span_off, h;
      u = lay_su * lay_dw;
      t = {32'd0, u} * lay_rows;
      s = t * {32'd0, lay_gt};
      m = (s == 0) ? '1 : off / s;
      span_off = off - m * s;
      g = (t == 0) ? 32'hFFFF_FFFF : 32'(span_off / t);
      h = span_off - {32'd0, g} * t;
      n = (u == 0) ? 32'hFFFF_FFFF : 32'(h / {32'd0, u});
      uoff = (lay_su == 0) ? off[31:0] : 32'(off % {32'd0, lay_su});
      low = uoff + n * lay_su;
      r.object_offset = {32'd0, low} + m * lay_rows * {32'd0, lay_su};
      inrow = 32'(h - {32'd0, 32'(n * u)});
      dev = ((lay_su == 0) ? 32'hFFFF_FFFF : inrow / lay_su) + g * lay_dw;
      r.component_index = dev * lay_cp;
      r.unit_offset = uoff;
      r.group_remaining = t - h;
      r.group_span = t;
      r.major_row = m;
      return r;
   endfunction

   function automatic void write_layout(logic [2:0] idx, logic [63:0] d);
      case (idx)
         CSR_STRIPE_UNIT: lay_su = d[31:0];
         CSR_DATA_WIDTH:  lay_dw = {16'd0, d[15:0]};
         CSR_ROWS:        lay_rows = d;
         CSR_GROUPS:      lay_gt = {16'd0, d[15:0]};
         CSR_COPIES:      lay_cp = {23'd0, d[8:0]};
         default: ;
      endcase
   endfunction

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         if (errors <= 10)
            $display("mismatch %s: expected %h actual %h at %0t", name, exp_v, act_v,
                     $realtime);
      end
   endtask

   // driver: offers one request or register write at a time
   always @(posedge clock) begin
      bit nx_start;
      bit nx_csr;
      op_type op;
      nx_start = start;
      nx_csr = csr_valid;
      if (reset) begin
         nx_start = 1'b0;
         nx_csr = 1'b0;
         hold = 0;
      end else begin
         if (start && !busy) begin
            expected_maps.push_back(map_offset(req_file_offset));
            n_maps++;
            nx_start = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            write_layout(csr_index, csr_wdata);
            n_csr++;
            nx_csr = 1'b0;
         end
         if (!nx_start && !nx_csr) begin
            if (hold > 0) hold--;
            else if (pending_ops.size() > 0) begin
               op = pending_ops[0];
               case (op.kind)
                  OP_MAP: begin
                     req_file_offset <= op.data;
                     nx_start = 1'b1;
                     void'(pending_ops.pop_front());
                     if ($urandom_range(0, 40) == 0) burst = ~burst;
                     hold = burst ? 0 : $urandom_range(0, 14);
                  end
                  OP_CSR: if (expected_maps.size() == 0) begin
                     csr_index <= op.idx;
                     csr_wdata <= op.data;
                     nx_csr = 1'b1;
                     void'(pending_ops.pop_front());
                  end
                  default: if (expected_maps.size() == 0)
                     void'(pending_ops.pop_front());
               endcase
            end
         end
      end
      start <= nx_start;
      csr_valid <= nx_csr;
   end

   // monitor: responses cannot be held off, check each one as it appears
   always @(posedge clock) begin
      mapping_type e;
      if (!reset && rsp_valid) begin
         if (expected_maps.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response at %0t", $realtime);
         end else begin
            e = expected_maps.pop_front();
            check_field("component_index", e.component_index, rsp_component_index);
            check_field("object_offset", e.object_offset, rsp_object_offset);
            check_field("unit_offset", e.unit_offset, rsp_unit_offset);
            check_field("group_remaining", e.group_remaining, rsp_group_remaining);
            check_field("group_span", e.group_span, rsp_group_span);
            check_field("major_row", e.major_row, rsp_major_row);
         end
      end
   end

   task automatic push_map(logic [63:0] off);
      pending_ops.push_back('{OP_MAP, 3'd0, off});
   endtask

   task automatic push_layout(logic [31:0] su, logic [15:0] dw, logic [63:0] rows,
                              logic [15:0] gt, logic [8:0] cp);
      // junk above the field width must be dropped by the block
      pending_ops.push_back('{OP_CSR, CSR_STRIPE_UNIT, {$urandom, su}});
      pending_ops.push_back('{OP_CSR, CSR_DATA_WIDTH, {$urandom, 16'($urandom), dw}});
      pending_ops.push_back('{OP_CSR, CSR_ROWS, rows});
      pending_ops.push_back('{OP_CSR, CSR_GROUPS, {$urandom, 16'($urandom), gt}});
      pending_ops.push_back('{OP_CSR, CSR_COPIES, {$urandom, 23'($urandom), cp}});
      // an index past the last register is ignored
      pending_ops.push_back('{OP_CSR, 3'(CSR_COPIES + $urandom_range(1, 3)),
                              {$urandom, $urandom}});
   endtask

   function automatic logic [63:0] rand_offset();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: return v;
         1: return v >> $urandom_range(0, 63);
         2: return v & 64'hFFFF_FFFF;
         default: return 64'(lay_su) * $urandom_range(0, 64) + $urandom_range(0, 2) - 1;
      endcase
   endfunction

   initial begin
      logic [63:0] dir_offsets[$];
      logic [31:0] su;
      logic [15:0] dw;
      logic [63:0] rows;
      logic [15:0] gt;
      logic [8:0]  cp;
      errors = 0;
      n_maps = 0;
      n_csr = 0;
      burst = 0;
      done = 0;
      reset = 1'b1;
      start = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_STRIPE_UNIT;
      csr_wdata = '0;
      req_file_offset = '0;
      lay_su = SU_RESET;
      lay_dw = 32'(DW_RESET);
      lay_rows = ROWS_RESET;
      lay_gt = 32'(GT_RESET);
      lay_cp = 32'(CP_RESET);

      dir_offsets = '{64'd0, 64'd1, '1, 64'h8000_0000_0000_0000, 64'd65535, 64'd65536,
                      64'd65537, 64'hFFFF_FFFF, 64'h1_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                      64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};
      // reset layout: one group of all-ones rows
      foreach (dir_offsets[i]) push_map(dir_offsets[i]);
      pending_ops.push_back('{OP_DRAIN, 3'd0, 64'd0});
      // small layout, boundaries of rows and groups
      push_layout(32'd4, 16'd3, 64'd2, 16'd5, 9'd2);
      for (int k = 0; k < 12; k++) push_map(64'(k * 12 + (k % 3)));
      push_map(64'd119);
      push_map(64'd120);
      push_map('1);

      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0: begin su = 32'd1; dw = 16'd1; rows = 64'd1; gt = 16'd1; cp = 9'd1; end
            1: begin su = '1; dw = '1; rows = '1; gt = '1; cp = 9'd256; end
            2: begin su = 32'd0; dw = 16'd1; rows = 64'd4; gt = 16'd2; cp = 9'd0; end
            3: begin
               su = 32'h8000_0000; dw = 16'd2; rows = 64'd3; gt = 16'd1; cp = 9'd3;
            end
            4: begin su = 32'd4096; dw = 16'd4; rows = '1; gt = 16'd3; cp = 9'd511; end
            default: begin
               su = ($urandom_range(0, 3) == 0) ? $urandom : 32'(4096) << $urandom_range(0, 8);
               dw = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12));
               case ($urandom_range(0, 3))
                  0: rows = '1;
                  1: rows = {$urandom, $urandom};
                  default: rows = 64'($urandom_range(1, 64));
               endcase
               gt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8));
               cp = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(1, 4));
            end
         endcase
         push_layout(su, dw, rows, gt, cp);
         // predictor layout lags here; offsets only need a rough scale
         lay_su = su;
         for (int k = 0; k < 70; k++) push_map(rand_offset());
         pending_ops.push_back('{OP_DRAIN, 3'd0, 64'd0});
      end
      // restore the block's view; the driver rewrites it on every accepted write
      lay_su = SU_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (!(pending_ops.size() == 0 && !start && !csr_valid &&
               expected_maps.size() == 0))
         @(posedge clock);
      repeat (PIPE_LATENCY + 20) @(posedge clock);
      errors += expected_maps.size();
      done = 1;
      $display("mapped %0d offsets over %0d register writes, %0d mismatches", n_maps, n_csr,
               errors);
      if (errors == 0) $display("tb_stripe_offset_to_component_map_top: clean");
      else $display("tb_stripe_offset_to_component_map_top: errors");
      $finish;
   end

   initial begin
      #5_000_000;
      if (!done) begin
         $display("timeout with %0d responses outstanding", expected_maps.size());
         $display("tb_stripe_offset_to_component_map_top: errors");
         $finish;
      end
   end

endmodule

// ===== files.f =====
design/sotc_pkg.sv
design/sotc_div.sv
design/stripe_offset_to_component_map_top.sv
design/sotc_chk.sv
bench/tb_stripe_offset_to_component_map_top.sv
